FILE: sv/kpa_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and reset values for the keypad PIN alarm controller.
// No dependencies; imported by every module of the block.
package kpa_pkg;

   // Operating modes
   typedef enum logic [1:0] {
      MODE_ARMED    = 2'd0,
      MODE_DISARMED = 2'd1,
      MODE_LOCKDOWN = 2'd2
   } mode_type;

   // Remote command codes
   localparam logic [1:0] CMD_NONE       = 2'd0;
   localparam logic [1:0] CMD_DISARM     = 2'd1;
   localparam logic [1:0] CMD_ARM        = 2'd2;

   // Key event codes
   localparam logic [2:0] KEV_NONE       = 3'd0;
   localparam logic [2:0] KEV_AUTH_OK    = 3'd1;
   localparam logic [2:0] KEV_WRONG_PIN  = 3'd2;
   localparam logic [2:0] KEV_BRUTE      = 3'd3;
   localparam logic [2:0] KEV_LOCAL_ARM  = 3'd4;

   // Alarm event codes
   localparam logic [1:0] AEV_NONE       = 2'd0;
   localparam logic [1:0] AEV_INTRUSION  = 2'd1;
   localparam logic [1:0] AEV_TRACKING   = 2'd2;

   // Remote event codes
   localparam logic [1:0] REV_NONE       = 2'd0;
   localparam logic [1:0] REV_DISARM     = 2'd1;
   localparam logic [1:0] REV_ARM        = 2'd2;

   // Special keys
   localparam logic [3:0] KEY_STAR       = 4'd12;
   localparam logic [3:0] KEY_HASH       = 4'd14;

   localparam logic [15:0] AGE_MAX       = 16'hFFFF;

   // Register indexes (word address)
   localparam logic [1:0] REG_MASTER_CODE   = 2'd0;
   localparam logic [1:0] REG_FAIL_LIMIT    = 2'd1;
   localparam logic [1:0] REG_BLINK_PERIOD  = 2'd2;
   localparam logic [1:0] REG_TRACK_COOL    = 2'd3;

   // Register reset values
   localparam logic [15:0] RST_MASTER_CODE  = 16'd292;
   localparam logic [3:0]  RST_FAIL_LIMIT   = 4'd3;
   localparam logic [15:0] RST_BLINK_PERIOD = 16'd300;
   localparam logic [15:0] RST_TRACK_COOL   = 16'd10000;

   typedef struct packed {
      logic [15:0] master_code;
      logic [3:0]  fail_limit;
      logic [15:0] blink_period_ms;
      logic [15:0] track_cooldown_ms;
   } cfg_type;

   typedef struct packed {
      logic       key_valid;
      logic [3:0] key_code;
      logic       motion;
      logic       door_open;
      logic [1:0] remote_cmd;
      logic       ms_tick;
   } req_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       lock_open;
      logic       relay_on;
      logic       led_on;
      logic       siren_on;
      logic       key_beep;
      logic [1:0] digits_entered;
      logic [2:0] key_event;
      logic [1:0] alarm_event;
      logic [1:0] remote_event;
   } rsp_type;

   // Scalar controller state carried from poll to poll
   typedef struct packed {
      mode_type    mode;
      logic [3:0]  fail_cnt;
      logic [15:0] blink_age;
      logic [15:0] track_age;
      logic        blink_phase;
      logic        lock;
      logic        relay;
      logic        led;
      logic        siren;
   } st_type;

   // Expected key of the master code at a position counted from the last digit
   function automatic logic [3:0] code_digit(input logic [15:0] code, input int pos);
      logic [3:0] d;
      case (pos)
         0:       d = code[3:0];
         1:       d = code[7:4];
         2:       d = code[11:8];
         3:       d = code[15:12];
         default: d = 4'h0;
      endcase
      return d;
   endfunction

endpackage

FILE: sv/kpa_csr.sv
`timescale 1ns / 1ps
// Configuration register file with an APB-style access port.
// Depends on kpa_pkg for register indexes, reset values and cfg_type.
module kpa_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output kpa_pkg::cfg_type    cfg
);
   import kpa_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   // Write on the access phase of a write transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.master_code       <= RST_MASTER_CODE;
         cfg_ff.fail_limit        <= RST_FAIL_LIMIT;
         cfg_ff.blink_period_ms   <= RST_BLINK_PERIOD;
         cfg_ff.track_cooldown_ms <= RST_TRACK_COOL;
      end else if (wr_en) begin
         case (reg_idx)
            REG_MASTER_CODE:  cfg_ff.master_code       <= csr_pwdata[15:0];
            REG_FAIL_LIMIT:   cfg_ff.fail_limit        <= csr_pwdata[3:0];
            REG_BLINK_PERIOD: cfg_ff.blink_period_ms   <= csr_pwdata[15:0];
            REG_TRACK_COOL:   cfg_ff.track_cooldown_ms <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      case (reg_idx)
         REG_MASTER_CODE:  csr_prdata = {16'h0, cfg_ff.master_code};
         REG_FAIL_LIMIT:   csr_prdata = {28'h0, cfg_ff.fail_limit};
         REG_BLINK_PERIOD: csr_prdata = {16'h0, cfg_ff.blink_period_ms};
         REG_TRACK_COOL:   csr_prdata = {16'h0, cfg_ff.track_cooldown_ms};
         default:          csr_prdata = 32'h0;
      endcase
   end

endmodule

FILE: sv/kpa_step.sv
`timescale 1ns / 1ps
// Next-state and result logic for one poll of the alarm controller.
// Depends on kpa_pkg for types, codes and the master code digit lookup.
module kpa_step #(
   parameter int PIN_DIGITS = 4
) (
   input  kpa_pkg::cfg_type                          cfg,
   input  kpa_pkg::req_type                          req,
   input  kpa_pkg::st_type                           st,
   input  logic [((PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1)-1:0] cnt,
   input  logic [((PIN_DIGITS > 1) ? PIN_DIGITS - 1 : 1)-1:0][3:0] pin_buf,
   output kpa_pkg::st_type                           st_next,
   output logic [((PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1)-1:0] cnt_next,
   output logic [((PIN_DIGITS > 1) ? PIN_DIGITS - 1 : 1)-1:0]      buf_we,
   output kpa_pkg::rsp_type                          rsp
);
   import kpa_pkg::*;

   localparam int CW = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
   localparam int BD = (PIN_DIGITS > 1) ? PIN_DIGITS - 1 : 1;
   localparam logic [CW-1:0] LAST_POS = CW'(PIN_DIGITS - 1);

   always_comb begin
      st_type          s;
      logic [CW-1:0]   c;
      logic [CW+1:0]   c_ext;
      logic            is_clear;
      logic            is_digit;
      logic            full;
      logic            match;
      logic [3:0]      fail_inc;
      logic            beep;
      logic [2:0]      kev;
      logic [1:0]      aev;
      logic [1:0]      rev;

      s      = st;
      c      = cnt;
      beep   = 1'b0;
      kev    = KEV_NONE;
      aev    = AEV_NONE;
      rev    = REV_NONE;
      buf_we = '0;

      // Saturating millisecond ages
      if (req.ms_tick) begin
         if (s.blink_age != AGE_MAX) s.blink_age = s.blink_age + 16'd1;
         if (s.track_age != AGE_MAX) s.track_age = s.track_age + 16'd1;
      end

      // Remote command goes first
      case (req.remote_cmd)
         CMD_DISARM: begin
            s.mode  = MODE_DISARMED;
            s.lock  = 1'b1;
            s.relay = 1'b0;
            s.led   = 1'b0;
            s.siren = 1'b0;
            rev     = REV_DISARM;
         end
         CMD_ARM: begin
            s.mode = MODE_ARMED;
            s.lock = 1'b0;
            c      = '0;
            rev    = REV_ARM;
         end
         default: ;
      endcase

      is_clear = (req.key_code == KEY_STAR) || (req.key_code == KEY_HASH);
      is_digit = req.key_valid && !is_clear;
      full     = is_digit && (c == LAST_POS);

      // Stored digits plus the key of this poll against the master code
      match = (req.key_code == code_digit(cfg.master_code, 0));
      for (int i = 0; i < PIN_DIGITS - 1; i++) begin
         if (pin_buf[i] != code_digit(cfg.master_code, PIN_DIGITS - 1 - i)) match = 1'b0;
      end
      fail_inc = s.fail_cnt + 4'd1;

      // Per-mode step
      case (s.mode)
         MODE_ARMED: begin
            if (req.key_valid) begin
               if (is_clear) begin
                  c = '0;
               end else begin
                  beep = 1'b1;
                  if (PIN_DIGITS > 1) begin
                     for (int j = 0; j < BD; j++) buf_we[j] = (c == CW'(j));
                  end
                  c = full ? '0 : c + CW'(1);
               end
               if (full) begin
                  if (match) begin
                     s.mode     = MODE_DISARMED;
                     s.lock     = 1'b1;
                     s.fail_cnt = 4'd0;
                     kev        = KEV_AUTH_OK;
                  end else if (fail_inc >= cfg.fail_limit) begin
                     s.fail_cnt = 4'd0;
                     kev        = KEV_BRUTE;
                  end else begin
                     s.fail_cnt = fail_inc;
                     kev        = KEV_WRONG_PIN;
                  end
               end
            end
            // Sensors force lockdown in the same poll
            if (req.door_open || req.motion) begin
               s.mode  = MODE_LOCKDOWN;
               s.lock  = 1'b0;
               s.relay = 1'b1;
               aev     = AEV_INTRUSION;
            end
         end
         MODE_DISARMED: begin
            if (req.key_valid && (req.key_code == KEY_HASH)) begin
               s.mode = MODE_ARMED;
               s.lock = 1'b0;
               c      = '0;
               kev    = KEV_LOCAL_ARM;
            end
         end
         default: begin
            // Lockdown: blink LED and siren, rate-limit tracking reports
            if (s.blink_age > cfg.blink_period_ms) begin
               s.blink_phase = !s.blink_phase;
               s.led         = s.blink_phase;
               s.siren       = s.blink_phase;
               s.blink_age   = 16'd0;
            end
            if (req.motion && (s.track_age > cfg.track_cooldown_ms)) begin
               aev         = AEV_TRACKING;
               s.track_age = 16'd0;
            end
         end
      endcase

      c_ext = {2'b00, c};

      st_next  = s;
      cnt_next = c;

      rsp.mode           = s.mode;
      rsp.lock_open      = s.lock;
      rsp.relay_on       = s.relay;
      rsp.led_on         = s.led;
      rsp.siren_on       = s.siren;
      rsp.key_beep       = beep;
      rsp.digits_entered = c_ext[1:0];
      rsp.key_event      = kev;
      rsp.alarm_event    = aev;
      rsp.remote_event   = rev;
   end

endmodule

FILE: sv/keypad_pin_alarm_controller.sv
`timescale 1ns / 1ps
// Top level of the keypad PIN alarm controller: input register, state, result register.
// Depends on kpa_pkg, kpa_csr and kpa_step.
//
//   Port group   Direction  Transfer rule
//   req_*        in         req_valid high and req_stall low at a rising edge
//   rsp_*        out        rsp_valid high and rsp_stall low at a rising edge
//   csr_*        in/out     write at psel, penable, pwrite, pready all high
//
// One poll per clock while rsp_stall stays low; a poll passes the input register, then the result register.
// The poll step is one pass of logic between the input register and the result register.
// Reset is synchronous; it clears both valid flags, the mode, the digit count and the scalar state, not the PIN digits.
// A stalled result holds; the input register then takes a new poll only while it is empty.
module keypad_pin_alarm_controller #(
   parameter int PIN_DIGITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_key_valid,
   input  logic [3:0]  req_key_code,
   input  logic        req_motion,
   input  logic        req_door_open,
   input  logic [1:0]  req_remote_cmd,
   input  logic        req_ms_tick,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_mode,
   output logic        rsp_lock_open,
   output logic        rsp_relay_on,
   output logic        rsp_led_on,
   output logic        rsp_siren_on,
   output logic        rsp_key_beep,
   output logic [1:0]  rsp_digits_entered,
   output logic [2:0]  rsp_key_event,
   output logic [1:0]  rsp_alarm_event,
   output logic [1:0]  rsp_remote_event,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import kpa_pkg::*;

   localparam int CW = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
   localparam int BD = (PIN_DIGITS > 1) ? PIN_DIGITS - 1 : 1;

   cfg_type              cfg;
   req_type              req_ff;
   logic                 req_v_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 rsp_v_ff;
   st_type               st_ff;
   st_type               st_in;
   logic [CW-1:0]        cnt_ff;
   logic [CW-1:0]        cnt_in;
   logic [BD-1:0][3:0]   buf_ff;
   logic [BD-1:0]        buf_we;
   logic                 adv;
   logic                 load;

   kpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   kpa_step #(
      .PIN_DIGITS (PIN_DIGITS)
   ) u_step (
      .cfg      (cfg),
      .req      (req_ff),
      .st       (st_ff),
      .cnt      (cnt_ff),
      .pin_buf  (buf_ff),
      .st_next  (st_in),
      .cnt_next (cnt_in),
      .buf_we   (buf_we),
      .rsp      (rsp_in)
   );

   // Advance a poll when the result register is empty or being taken
   assign adv       = req_v_ff && (!rsp_v_ff || !rsp_stall);
   assign load      = !req_v_ff || adv;
   assign req_stall = !load;
   assign rsp_valid = rsp_v_ff;

   // Valid flags and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_v_ff          <= 1'b0;
         rsp_v_ff          <= 1'b0;
         st_ff.mode        <= MODE_ARMED;
         st_ff.fail_cnt    <= 4'd0;
         st_ff.blink_age   <= 16'd0;
         st_ff.track_age   <= 16'd0;
         st_ff.blink_phase <= 1'b0;
         st_ff.lock        <= 1'b0;
         st_ff.relay       <= 1'b0;
         st_ff.led         <= 1'b0;
         st_ff.siren       <= 1'b0;
         cnt_ff            <= '0;
      end else begin
         if (load) req_v_ff <= req_valid;
         if (adv) begin
            rsp_v_ff <= 1'b1;
            st_ff    <= st_in;
            cnt_ff   <= cnt_in;
         end else if (!rsp_stall) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   // Capture the request payload
   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         req_ff.key_valid  <= req_key_valid;
         req_ff.key_code   <= req_key_code;
         req_ff.motion     <= req_motion;
         req_ff.door_open  <= req_door_open;
         req_ff.remote_cmd <= req_remote_cmd;
         req_ff.ms_tick    <= req_ms_tick;
      end
   end

   // Hold the result and the PIN digits
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
         for (int j = 0; j < BD; j++) begin
            if (buf_we[j]) buf_ff[j] <= req_ff.key_code;
         end
      end
   end

   assign rsp_mode           = rsp_ff.mode;
   assign rsp_lock_open      = rsp_ff.lock_open;
   assign rsp_relay_on       = rsp_ff.relay_on;
   assign rsp_led_on         = rsp_ff.led_on;
   assign rsp_siren_on       = rsp_ff.siren_on;
   assign rsp_key_beep       = rsp_ff.key_beep;
   assign rsp_digits_entered = rsp_ff.digits_entered;
   assign rsp_key_event      = rsp_ff.key_event;
   assign rsp_alarm_event    = rsp_ff.alarm_event;
   assign rsp_remote_event   = rsp_ff.remote_event;

endmodule

FILE: tb/sv/keypad_pin_alarm_controller_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for keypad_pin_alarm_controller: directed and random polls.
// Depends on kpa_pkg and the controller RTL; a tracker class predicts each result.
module keypad_pin_alarm_controller_test;
   import kpa_pkg::*;

   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   // Predict the controller state and queue one expected result per poll
   class alarm_tracker;
      logic [15:0] master_code = RST_MASTER_CODE;
      logic [3:0]  fail_limit = RST_FAIL_LIMIT;
      logic [15:0] blink_period = RST_BLINK_PERIOD;
      logic [15:0] track_cooldown = RST_TRACK_COOL;

      mode_type    mode = MODE_ARMED;
      logic [3:0]  digits [4];
      int          count = 0;
      logic [3:0]  fails = '0;
      logic [15:0] blink_age = '0;
      logic [15:0] track_age = '0;
      logic        blink_phase = 1'b0;
      logic        lock = 1'b0, relay = 1'b0, led = 1'b0, siren = 1'b0;

      rsp_type     pending_results [$];
      int          mismatches = 0;

      function void set_reg(logic [1:0] idx, logic [15:0] value);
         case (idx)
            REG_MASTER_CODE:  master_code = value;
            REG_FAIL_LIMIT:   fail_limit = value[3:0];
            REG_BLINK_PERIOD: blink_period = value;
            REG_TRACK_COOL:   track_cooldown = value;
            default: ;
         endcase
      endfunction

      function void poll_accepted(req_type p);
         rsp_type r;
         bit      hit;
         r = '0;
         // advance the millisecond ages, saturating
         if (p.ms_tick) begin
            if (blink_age != AGE_MAX) blink_age++;
            if (track_age != AGE_MAX) track_age++;
         end
         // remote command goes first
         if (p.remote_cmd == CMD_DISARM) begin
            mode = MODE_DISARMED;
            lock = 1'b1;
            relay = 1'b0;
            led = 1'b0;
            siren = 1'b0;
            r.remote_event = REV_DISARM;
         end else if (p.remote_cmd == CMD_ARM) begin
            mode = MODE_ARMED;
            lock = 1'b0;
            count = 0;
            r.remote_event = REV_ARM;
         end
         case (mode)
            MODE_ARMED: begin
               if (p.key_valid) begin
                  if (p.key_code == KEY_STAR || p.key_code == KEY_HASH) begin
                     count = 0;
                  end else begin
                     digits[count] = p.key_code;
                     count++;
                     r.key_beep = 1'b1;
                  end
                  // full entry: compare against the master code, first digit on top
                  if (count == 4) begin
                     hit = 1'b1;
                     for (int i = 0; i < 4; i++)
                        if (digits[i] != master_code[4*(3-i) +: 4]) hit = 1'b0;
                     if (hit) begin
                        mode = MODE_DISARMED;
                        lock = 1'b1;
                        fails = '0;
                        r.key_event = KEV_AUTH_OK;
                     end else begin
                        fails = fails + 4'd1;
                        if (fails >= fail_limit) begin
                           r.key_event = KEV_BRUTE;
                           fails = '0;
                        end else begin
                           r.key_event = KEV_WRONG_PIN;
                        end
                     end
                     count = 0;
                  end
               end
               // sensors override whatever the keypad did
               if (p.door_open || p.motion) begin
                  mode = MODE_LOCKDOWN;
                  lock = 1'b0;
                  relay = 1'b1;
                  r.alarm_event = AEV_INTRUSION;
               end
            end
            MODE_DISARMED: begin
               if (p.key_valid && p.key_code == KEY_HASH) begin
                  mode = MODE_ARMED;
                  lock = 1'b0;
                  count = 0;
                  r.key_event = KEV_LOCAL_ARM;
               end
            end
            default: begin
               if (blink_age > blink_period) begin
                  blink_phase = !blink_phase;
                  led = blink_phase;
                  siren = blink_phase;
                  blink_age = '0;
               end
               if (p.motion && track_age > track_cooldown) begin
                  r.alarm_event = AEV_TRACKING;
                  track_age = '0;
               end
            end
         endcase
         r.mode = mode;
         r.lock_open = lock;
         r.relay_on = relay;
         r.led_on = led;
         r.siren_on = siren;
         r.digits_entered = count[1:0];
         pending_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [3:0] want, logic [3:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void result_seen(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $error("result transfer with no poll outstanding");
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("mode", want.mode, got.mode);
         compare_field("lock_open", want.lock_open, got.lock_open);
         compare_field("relay_on", want.relay_on, got.relay_on);
         compare_field("led_on", want.led_on, got.led_on);
         compare_field("siren_on", want.siren_on, got.siren_on);
         compare_field("key_beep", want.key_beep, got.key_beep);
         compare_field("digits_entered", want.digits_entered, got.digits_entered);
         compare_field("key_event", want.key_event, got.key_event);
         compare_field("alarm_event", want.alarm_event, got.alarm_event);
         compare_field("remote_event", want.remote_event, got.remote_event);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_key_valid;
   logic [3:0]  req_key_code;
   logic        req_motion;
   logic        req_door_open;
   logic [1:0]  req_remote_cmd;
   logic        req_ms_tick;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_mode;
   logic        rsp_lock_open;
   logic        rsp_relay_on;
   logic        rsp_led_on;
   logic        rsp_siren_on;
   logic        rsp_key_beep;
   logic [1:0]  rsp_digits_entered;
   logic [2:0]  rsp_key_event;
   logic [1:0]  rsp_alarm_event;
   logic [1:0]  rsp_remote_event;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   alarm_tracker tracker = new();
   int send_idle_pct = 20;
   int recv_idle_pct = 50;
   int polls_sent = 0;

   keypad_pin_alarm_controller u_top (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Random single bit
   function automatic logic coin();
      return 1'($urandom_range(1));
   endfunction

   // Stall the result channel at random and check every result transfer
   always @(posedge clock) begin
      rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
      if (!reset && rsp_valid && !rsp_stall)
         tracker.result_seen('{mode: rsp_mode, lock_open: rsp_lock_open,
                               relay_on: rsp_relay_on, led_on: rsp_led_on,
                               siren_on: rsp_siren_on, key_beep: rsp_key_beep,
                               digits_entered: rsp_digits_entered,
                               key_event: rsp_key_event, alarm_event: rsp_alarm_event,
                               remote_event: rsp_remote_event});
   end

   // Offer one poll, with an optional idle gap first; return once it transfers
   task automatic send_poll(input logic kv, input logic [3:0] kc, input logic mo,
                            input logic dr, input logic [1:0] rc, input logic tk);
      req_type p;
      p = '{key_valid: kv, key_code: kc, motion: mo, door_open: dr,
            remote_cmd: rc, ms_tick: tk};
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_key_valid <= p.key_valid;
      req_key_code <= p.key_code;
      req_motion <= p.motion;
      req_door_open <= p.door_open;
      req_remote_cmd <= p.remote_cmd;
      req_ms_tick <= p.ms_tick;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.poll_accepted(p);
      polls_sent++;
   endtask

   // Drop valid and hold until every expected result has transferred
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      tracker.set_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic program_alarm(input logic [15:0] code, input logic [3:0] limit,
                                input logic [15:0] blink, input logic [15:0] cool);
      write_reg(REG_MASTER_CODE, code);
      write_reg(REG_FAIL_LIMIT, {12'd0, limit});
      write_reg(REG_BLINK_PERIOD, blink);
      write_reg(REG_TRACK_COOL, cool);
   endtask

   // One random stretch of polls, mostly well-formed user behavior
   task automatic run_episode();
      int         sel;
      int         bad;
      logic [3:0] k;
      logic       mo;
      sel = $urandom_range(99);
      if (sel < 45) begin
         // PIN entry, right or with one random digit
         if (tracker.mode != MODE_ARMED)
            send_poll(0, 4'($urandom), 0, 0, CMD_ARM, coin());
         bad = ($urandom_range(2) == 0) ? $urandom_range(3) : -1;
         for (int i = 0; i < 4; i++) begin
            if ($urandom_range(11) == 0)
               send_poll(1, coin() ? KEY_STAR : KEY_HASH, 0, 0, CMD_NONE, coin());
            k = (i == bad) ? 4'($urandom) : tracker.master_code[4*(3-i) +: 4];
            mo = (i == 3) && ($urandom_range(15) == 0);
            send_poll(1, k, mo & coin(), mo, CMD_NONE, coin());
         end
      end else if (sel < 60) begin
         // trip the sensors, dwell in lockdown, then leave by remote, mostly by disarm
         mo = coin();
         send_poll(coin(), 4'($urandom), mo, !mo | coin(), CMD_NONE, coin());
         repeat ($urandom_range(3, 25))
            send_poll(coin(), 4'($urandom), coin(), coin(),
                      ($urandom_range(9) == 0) ? CMD_UNKNOWN : CMD_NONE,
                      $urandom_range(4) != 0);
         if ($urandom_range(4) != 0)
            send_poll(0, 4'($urandom), 0, 0, CMD_DISARM, coin());
         else
            send_poll(0, 4'($urandom), 0, 0, CMD_ARM, coin());
      end else if (sel < 72) begin
         // disarmed: stray keys, then usually a local arm
         send_poll(coin(), 4'($urandom), coin(), coin(), CMD_DISARM, coin());
         repeat ($urandom_range(4))
            send_poll(coin(), 4'($urandom), coin(), coin(), CMD_NONE, coin());
         if ($urandom_range(9) < 7)
            send_poll(1, KEY_HASH, 0, 0, CMD_NONE, coin());
      end else if (sel < 80) begin
         send_poll(coin(), 4'($urandom), coin(), coin(), CMD_ARM, coin());
      end else begin
         send_poll(coin(), 4'($urandom), coin(), coin(), 2'($urandom_range(3)), coin());
      end
   endtask

   initial begin
      logic [15:0] pin;
      logic [3:0]  k;
      int          target;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_key_valid <= 1'b0;
      req_key_code <= '0;
      req_motion <= 1'b0;
      req_door_open <= 1'b0;
      req_remote_cmd <= CMD_NONE;
      req_ms_tick <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed polls under the reset settings (code 0,1,2,4)
      send_poll(0, 4'd0, 0, 0, CMD_NONE, 1);
      send_poll(1, 4'd0, 0, 0, CMD_NONE, 1);
      send_poll(1, 4'd1, 0, 0, CMD_NONE, 0);
      send_poll(1, 4'd2, 0, 0, CMD_NONE, 1);
      send_poll(1, 4'd4, 0, 0, CMD_NONE, 0);
      send_poll(1, 4'd3, 0, 0, CMD_UNKNOWN, 1);
      send_poll(1, KEY_HASH, 0, 0, CMD_NONE, 0);
      send_poll(1, 4'd13, 0, 0, CMD_NONE, 0);
      send_poll(1, KEY_STAR, 0, 0, CMD_NONE, 1);
      repeat (4) send_poll(1, 4'd15, 0, 0, CMD_NONE, 1);
      send_poll(1, 4'd10, 0, 0, CMD_NONE, 0);
      send_poll(1, 4'd11, 0, 0, CMD_NONE, 0);
      send_poll(1, 4'd13, 0, 0, CMD_NONE, 0);
      send_poll(1, 4'd15, 0, 0, CMD_NONE, 0);
      send_poll(1, 4'd0, 0, 0, CMD_NONE, 1);
      send_poll(1, 4'd1, 0, 0, CMD_NONE, 1);
      send_poll(1, 4'd2, 0, 0, CMD_NONE, 1);
      send_poll(1, 4'd5, 0, 0, CMD_NONE, 1);
      send_poll(1, 4'd0, 0, 0, CMD_NONE, 0);
      send_poll(1, 4'd1, 0, 0, CMD_NONE, 0);
      send_poll(1, 4'd2, 0, 0, CMD_NONE, 0);
      send_poll(1, 4'd4, 0, 1, CMD_NONE, 1);
      send_poll(1, 4'd7, 1, 0, CMD_ARM, 1);
      send_poll(0, 4'd0, 0, 0, CMD_DISARM, 1);
      send_poll(1, KEY_HASH, 0, 0, CMD_ARM, 0);

      // Random phases, each under its own settings
      for (int ph = 0; ph < 5; ph++) begin
         settle();
         case (ph)
            0: program_alarm(16'hFFFF, 4'd15, 16'd1, 16'd1);
            1: program_alarm(16'h0000, 4'd1, 16'hFFFF, 16'hFFFF);
            2: program_alarm(16'($urandom), 4'd0, 16'($urandom_range(2, 20)),
                             16'($urandom_range(3, 40)));
            3: begin
               // keep every digit enterable so a match is reachable
               for (int i = 0; i < 4; i++) begin
                  do k = 4'($urandom); while (k == KEY_STAR || k == KEY_HASH);
                  pin[4*i +: 4] = k;
               end
               program_alarm(pin, 4'($urandom_range(2, 6)), 16'($urandom_range(1, 10)),
                             16'($urandom_range(1, 100)));
            end
            default: program_alarm(RST_MASTER_CODE, RST_FAIL_LIMIT, RST_BLINK_PERIOD,
                                   RST_TRACK_COOL);
         endcase
         if (ph < 2) begin
            send_idle_pct = 20;
            recv_idle_pct = 50;
         end else if (ph < 4) begin
            send_idle_pct = 50;
            recv_idle_pct = 20;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         target = polls_sent + 250;
         while (polls_sent < target) run_episode();
      end
      settle();

      if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: filelist.f
sv/kpa_pkg.sv
sv/kpa_csr.sv
sv/kpa_step.sv
sv/keypad_pin_alarm_controller.sv
tb/sv/keypad_pin_alarm_controller_test.sv
